/* hw/rtl/sfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find/replace unit
// Payload structs, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int TEXT_W    = 8;   // one text byte
  localparam int LEN_W     = 4;   // length register width
  localparam int WORD_W    = 64;  // pattern / replacement word
  localparam int CFG_IDX_W = 3;   // register index port
  localparam int REP_MAX   = 8;   // longest replacement
  localparam int REP_IDX_W = 3;   // index into the replacement word

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd3;

  typedef struct packed {
    logic [TEXT_W-1:0] text_byte;
    logic              end_of_text;
  } in_t;

  typedef struct packed {
    logic [TEXT_W-1:0] out_byte;
    logic              from_replacement;
    logic              last_of_run;
    logic              end_of_output;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REPL,
    ST_FLUSH,
    ST_FIN
  } state_t;

endpackage

/* hw/rtl/sfr_prefix_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_prefix_cmp: held-bytes prefix comparator
// Flags whether the held bytes are a prefix of the search pattern.
// ----------------------------------------------------------------------------
module sfr_prefix_cmp
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN = 8,
  parameter int CNT_W       = 4
) (
  input  logic [MAX_PATTERN*TEXT_W-1:0] held_flat,
  input  logic [CNT_W-1:0]              count,
  input  logic [CNT_W-1:0]              plen,
  input  logic [WORD_W-1:0]             pattern_bytes,
  output logic                          is_prefix
);

  // byte lanes compared side by side, masked beyond the fill count
  always_comb begin
    is_prefix = (count <= plen);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CNT_W'(i) < count) &&
          (held_flat[i*TEXT_W +: TEXT_W] != pattern_bytes[i*TEXT_W +: TEXT_W])) begin
        is_prefix = 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/stream_find_replace_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_unit: streaming find-and-replace over a byte stream
// Replaces leftmost, non-overlapping pattern hits with a replacement string.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one text byte per transfer, end_of_text on the final byte.
//   out channel : one rewritten byte per transfer; last_of_run closes the
//                 results caused by one input, end_of_output the whole text.
//   cfg channel : register writes (0 pattern length, 1 pattern bytes,
//                 2 replacement length, 3 replacement bytes); ready only
//                 while idle with no input offered, so an input offered in
//                 the same cycle goes first. Writing either pattern register
//                 drops held bytes.
// Timing:
//   in_ready stays low after an input transfer until every result byte that
//   transfer causes has been produced, so one input is handled at a time:
//   one result byte per cycle on the shared compare/shift datapath unless
//   the output stalls, plus a check and a close state.
//   Results reach the port through the pending slot and the output register.
// Reset: synchronous; clears the hold, the output register and restores
//   pattern length 1 / pattern 0x00 / replacement length 1 / replacement 0x00.
// Stall: one result waits in a pending slot and one in the output register;
//   the sequencer waits while both are full and it has a result to hand on.
// ----------------------------------------------------------------------------
module stream_find_replace_unit
  import sfr_pkg::*;
#(
  parameter int MAX_PATTERN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // configuration
  logic [LEN_W-1:0]  pattern_length;
  logic [WORD_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]  replacement_length;
  logic [WORD_W-1:0] replacement_bytes;

  // hold of a partial match
  logic [TEXT_W-1:0] held [MAX_PATTERN];
  logic [CNT_W-1:0]  count;
  logic              last_r;
  logic [REP_IDX_W-1:0] rep_idx;

  // pending result: sent on once we know whether another follows
  logic              pend_valid;
  logic [TEXT_W-1:0] pend_byte;
  logic              pend_rep;

  state_t state, state_next;

  logic [MAX_PATTERN*TEXT_W-1:0] held_flat;
  logic [CNT_W-1:0] plen_eff;
  logic [LEN_W-1:0] rlen_eff;
  logic             is_prefix;

  logic              accept, cfg_wr;
  logic              slot_free, can_go;
  logic              produce, prod_fire;
  logic [TEXT_W-1:0] prod_byte;
  logic              prod_rep;
  logic              drop, clr_cnt, rep_step;
  logic              push, fin_fire;
  out_t              push_data;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_flat
    assign held_flat[g*TEXT_W +: TEXT_W] = held[g];
  end

  // clamp lengths into their legal ranges
  always_comb begin
    if (pattern_length == '0) begin
      plen_eff = CNT_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      plen_eff = CNT_W'(MAX_PATTERN);
    end else begin
      plen_eff = CNT_W'(pattern_length);
    end
    if (replacement_length == '0) begin
      rlen_eff = LEN_W'(1);
    end else if (replacement_length > LEN_W'(REP_MAX)) begin
      rlen_eff = LEN_W'(REP_MAX);
    end else begin
      rlen_eff = replacement_length;
    end
  end

  sfr_prefix_cmp #(
    .MAX_PATTERN (MAX_PATTERN),
    .CNT_W       (CNT_W)
  ) u_cmp (
    .held_flat     (held_flat),
    .count         (count),
    .plen          (plen_eff),
    .pattern_bytes (pattern_bytes),
    .is_prefix     (is_prefix)
  );

  assign in_ready  = (state == ST_IDLE);
  // an offered input goes first; a write never lands in the same cycle
  assign cfg_ready = (state == ST_IDLE) && !in_valid;
  assign accept    = in_valid && in_ready;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign slot_free = !out_valid || out_ready;
  assign can_go    = !pend_valid || slot_free;
  assign prod_fire = produce && can_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    produce    = 1'b0;
    prod_byte  = held[0];
    prod_rep   = 1'b0;
    drop       = 1'b0;
    clr_cnt    = 1'b0;
    rep_step   = 1'b0;
    fin_fire   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((count != '0) && !is_prefix) begin
          // front byte can no longer start a match: send it and re-check
          produce = 1'b1;
          drop    = can_go;
        end else if (count == plen_eff) begin
          clr_cnt    = 1'b1;
          state_next = ST_REPL;
        end else if (last_r && (count != '0)) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_REPL: begin
        produce   = 1'b1;
        prod_byte = replacement_bytes[rep_idx*TEXT_W +: TEXT_W];
        prod_rep  = 1'b1;
        rep_step  = can_go;
        if (can_go && (LEN_W'(rep_idx) + LEN_W'(1) == rlen_eff)) begin
          state_next = ST_FIN;
        end
      end
      ST_FLUSH: begin
        produce = 1'b1;
        drop    = can_go;
        if (can_go && (count == CNT_W'(1))) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (slot_free) begin
          fin_fire   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign push = (prod_fire && pend_valid) || fin_fire;

  always_comb begin
    push_data.out_byte         = pend_byte;
    push_data.from_replacement = pend_rep;
    push_data.last_of_run      = fin_fire;
    push_data.end_of_output    = fin_fire && last_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= LEN_W'(1);
      pattern_bytes      <= '0;
      replacement_length <= LEN_W'(1);
      replacement_bytes  <= '0;
      count              <= '0;
      pend_valid         <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: begin
            pattern_length <= cfg_data[LEN_W-1:0];
            count          <= '0;
          end
          REG_PATTERN_BYTES: begin
            pattern_bytes <= cfg_data;
            count         <= '0;
          end
          REG_REPLACEMENT_LENGTH: begin
            replacement_length <= cfg_data[LEN_W-1:0];
          end
          REG_REPLACEMENT_BYTES: begin
            replacement_bytes <= cfg_data;
          end
          default: begin
          end
        endcase
      end

      if (accept) begin
        held[count[IDX_W-1:0]] <= in_data.text_byte;
        count                  <= count + CNT_W'(1);
      end else if (drop) begin
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          held[i] <= held[i+1];
        end
        count <= count - CNT_W'(1);
      end else if (clr_cnt) begin
        count <= '0;
      end

      if (prod_fire) begin
        pend_valid <= 1'b1;
      end else if (fin_fire) begin
        pend_valid <= 1'b0;
      end

      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r  <= in_data.end_of_text;
      rep_idx <= '0;
    end else if (rep_step) begin
      rep_idx <= rep_idx + REP_IDX_W'(1);
    end
    if (prod_fire) begin
      pend_byte <= prod_byte;
      pend_rep  <= prod_rep;
    end
    if (push) begin
      out_data <= push_data;
    end
  end

endmodule

/* hw/rtl/sfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_checker: port-level checks for the stream find/replace unit
// Observes the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input in_t                  in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_t                 out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [WORD_W-1:0]    cfg_data
);

  // one item at a time: busy straight after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous item still in work");

  // end of text always closes a run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.end_of_output |-> out_data.last_of_run)
    else $error("end_of_output without last_of_run");

  // config only taken when the sequencer can take input too
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> in_ready)
    else $error("config port open while busy");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (.*);
